@@ rtl/core/x86d_pkg.sv @@
// ----------------------------------------------------------------------------
// x86d_pkg
// Types, codes and small decode functions shared by the 8086 decoder core.
// ----------------------------------------------------------------------------
package x86d_pkg;

   // Opcode classes of the decoded subset
   typedef enum logic [2:0] {
      CL_NONE,
      CL_REGMEM,
      CL_MOVIMM,
      CL_ACCIMM,
      CL_GROUP,
      CL_JUMP
   } op_class_type;

   // Operand kinds
   typedef enum logic [1:0] {
      OPND_REG,
      OPND_MEM,
      OPND_IMM
   } opnd_kind_type;

   // Record status codes
   typedef enum logic [1:0] {
      ST_OK,
      ST_BAD_OPCODE,
      ST_BAD_EXT,
      ST_TRUNC
   } status_type;

   // What the byte collector hands to the record decoder
   typedef enum logic [1:0] {
      SNAP_DECODE,
      SNAP_BAD_OPCODE,
      SNAP_TRUNC
   } snap_kind_type;

   // Mnemonic codes
   localparam logic [4:0] MN_MOV      = 5'd0;
   localparam logic [4:0] MN_ADD      = 5'd1;
   localparam logic [4:0] MN_SUB      = 5'd2;
   localparam logic [4:0] MN_CMP      = 5'd3;
   localparam logic [4:0] MN_JCC_BASE = 5'd4;
   localparam logic [4:0] MN_LOOP     = 5'd20;
   localparam logic [4:0] MN_LOOPZ    = 5'd21;
   localparam logic [4:0] MN_LOOPNZ   = 5'd22;
   localparam logic [4:0] MN_JCXZ     = 5'd23;

   // Immediate group extensions (reg field of mod-reg-rm)
   localparam logic [2:0] EXT_ADD = 3'd0;
   localparam logic [2:0] EXT_SUB = 3'd5;
   localparam logic [2:0] EXT_CMP = 3'd7;

   // Opcode landmarks
   localparam logic [7:0] OP_MOV_RM_LO = 8'h88;
   localparam logic [7:0] OP_MOV_RM_HI = 8'h8b;
   localparam logic [7:0] OP_MOV_IM_LO = 8'hb0;
   localparam logic [7:0] OP_MOV_IM_HI = 8'hbf;
   localparam logic [7:0] OP_GRP_LO    = 8'h80;
   localparam logic [7:0] OP_GRP_HI    = 8'h83;
   localparam logic [7:0] OP_SUB_BASE  = 8'h28;
   localparam logic [7:0] OP_CMP_BASE  = 8'h38;
   localparam logic [7:0] OP_SUB_ACC   = 8'h2c;
   localparam logic [7:0] OP_CMP_ACC   = 8'h3c;
   localparam logic [7:0] OP_JCC_HI    = 8'h7f;
   localparam logic [7:0] OP_LOOPNZ    = 8'he0;
   localparam logic [7:0] OP_LOOPZ     = 8'he1;
   localparam logic [7:0] OP_LOOP      = 8'he2;
   localparam logic [7:0] OP_JCXZ      = 8'he3;

   localparam logic [1:0] MOD_REG      = 2'd3;
   localparam logic [2:0] RM_DIRECT    = 3'd6;
   localparam logic [3:0] AF_DIRECT    = 4'd8;

   // Snapshot of a finished instruction (or an error) after the last byte
   typedef struct packed {
      snap_kind_type kind;
      logic [7:0]    opcode;
      logic [7:0]    modrm;
      logic [15:0]   disp;
      logic [15:0]   imm;
      logic [2:0]    length;
   } snap_type;

   // One decoded record
   typedef struct packed {
      logic [4:0]         mnemonic;
      logic               wide_op;
      logic [1:0]         operand_total;
      logic [1:0]         dest_kind;
      logic [3:0]         dest_reg;
      logic [1:0]         src_kind;
      logic [3:0]         src_reg;
      logic [3:0]         address_form;
      logic signed [15:0] displacement;
      logic signed [15:0] immediate;
      logic [2:0]         length;
      logic [1:0]         status;
   } record_type;

   function automatic op_class_type op_class(input logic [7:0] op);
      op_class_type cls;
      cls = CL_NONE;
      if ((op >= OP_MOV_RM_LO && op <= OP_MOV_RM_HI) || op <= 8'h03 ||
          (op >= OP_SUB_BASE && op <= OP_SUB_BASE + 8'h03) ||
          (op >= OP_CMP_BASE && op <= OP_CMP_BASE + 8'h03)) begin
         cls = CL_REGMEM;
      end else if (op >= OP_MOV_IM_LO && op <= OP_MOV_IM_HI) begin
         cls = CL_MOVIMM;
      end else if (op == 8'h04 || op == 8'h05 || op == OP_SUB_ACC ||
                   op == OP_SUB_ACC + 8'h01 || op == OP_CMP_ACC ||
                   op == OP_CMP_ACC + 8'h01) begin
         cls = CL_ACCIMM;
      end else if (op >= OP_GRP_LO && op <= OP_GRP_HI) begin
         cls = CL_GROUP;
      end else if ((op >= 8'h70 && op <= OP_JCC_HI) ||
                   (op >= OP_LOOPNZ && op <= OP_JCXZ)) begin
         cls = CL_JUMP;
      end
      return cls;
   endfunction

   function automatic logic has_modrm(input op_class_type cls);
      return (cls == CL_REGMEM) || (cls == CL_GROUP);
   endfunction

   // Displacement bytes that follow a mod-reg-rm byte
   function automatic logic [1:0] disp_len(input logic [7:0] modrm);
      logic [1:0] len;
      unique case (modrm[7:6])
         2'd0:    len = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
         2'd1:    len = 2'd1;
         2'd2:    len = 2'd2;
         default: len = 2'd0;
      endcase
      return len;
   endfunction

   // Immediate bytes of an opcode
   function automatic logic [1:0] imm_len(input logic [7:0] op, input op_class_type cls);
      logic [1:0] len;
      unique case (cls)
         CL_MOVIMM: len = op[3] ? 2'd2 : 2'd1;
         CL_ACCIMM: len = op[0] ? 2'd2 : 2'd1;
         CL_GROUP:  len = (op[0] && !op[1]) ? 2'd2 : 2'd1;
         CL_JUMP:   len = 2'd1;
         default:   len = 2'd0;
      endcase
      return len;
   endfunction

   // Sign-extend a gathered value of 0, 1 or 2 bytes
   function automatic logic [15:0] sext(input logic [15:0] v, input logic [1:0] len);
      logic [15:0] r;
      unique case (len)
         2'd0:    r = 16'h0000;
         2'd1:    r = {{8{v[7]}}, v[7:0]};
         default: r = v;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/core/x86d_if.sv @@
// ----------------------------------------------------------------------------
// x86d_if
// Valid/ready channels of the decoder: code bytes in, decoded records out.
// ----------------------------------------------------------------------------
interface x86d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       stream_end;

   modport source (output valid, output code_byte, output stream_end, input ready);
   modport sink   (input valid, input code_byte, input stream_end, output ready);
endinterface

interface x86d_rsp_if;
   logic               valid;
   logic               ready;
   logic [4:0]         mnemonic;
   logic               wide_op;
   logic [1:0]         operand_total;
   logic [1:0]         dest_kind;
   logic [3:0]         dest_reg;
   logic [1:0]         src_kind;
   logic [3:0]         src_reg;
   logic [3:0]         address_form;
   logic signed [15:0] displacement;
   logic signed [15:0] immediate;
   logic [2:0]         length;
   logic [1:0]         status;

   modport source (output valid, output mnemonic, output wide_op, output operand_total,
                   output dest_kind, output dest_reg, output src_kind, output src_reg,
                   output address_form, output displacement, output immediate,
                   output length, output status, input ready);
   modport sink   (input valid, input mnemonic, input wide_op, input operand_total,
                   input dest_kind, input dest_reg, input src_kind, input src_reg,
                   input address_form, input displacement, input immediate,
                   input length, input status, output ready);
endinterface

@@ rtl/core/x86_16bit_instruction_decoder_core.sv @@
// ----------------------------------------------------------------------------
// x86_16bit_instruction_decoder_core
// Byte-serial 8086 decoder for mov, add/sub/cmp and the short jumps and loops.
// ----------------------------------------------------------------------------
// Takes one code byte per cycle and sustains that rate while results are
// taken. Each byte passes an input register, then one pass of collect and
// decode logic into the result register, which then offers the record of the
// instruction that the byte completes (or ends).
// Bytes that do not complete an instruction give no record. Unknown opcodes,
// unknown group extensions and stream_end inside an instruction give error
// records; the next byte then starts a new instruction. A stalled result
// holds the result register and the byte waiting in the input register, so
// the core takes at most one more byte until the result is taken.
module x86_16bit_instruction_decoder_core (
   input  logic              clock,
   input  logic              reset,
   x86d_req_if.sink          req_bus,
   x86d_rsp_if.source        rsp_bus
);
   import x86d_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   record_type rsp_rec_ff;
   logic       advance;
   logic       emit;
   snap_type   snap;
   record_type rec;

   // Input stage moves on when the result register can take its outcome
   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_byte_ff <= req_bus.code_byte;
         in_end_ff  <= req_bus.stream_end;
      end
   end

   x86d_collect u_collect (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .code_byte  (in_byte_ff),
      .stream_end (in_end_ff),
      .emit       (emit),
      .snap       (snap)
   );

   x86d_decode u_decode (
      .snap (snap),
      .rec  (rec)
   );

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_rec_ff <= rec;
      end
   end

   // Result transfer
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.mnemonic      = rsp_rec_ff.mnemonic;
   assign rsp_bus.wide_op       = rsp_rec_ff.wide_op;
   assign rsp_bus.operand_total = rsp_rec_ff.operand_total;
   assign rsp_bus.dest_kind     = rsp_rec_ff.dest_kind;
   assign rsp_bus.dest_reg      = rsp_rec_ff.dest_reg;
   assign rsp_bus.src_kind      = rsp_rec_ff.src_kind;
   assign rsp_bus.src_reg       = rsp_rec_ff.src_reg;
   assign rsp_bus.address_form  = rsp_rec_ff.address_form;
   assign rsp_bus.displacement  = rsp_rec_ff.displacement;
   assign rsp_bus.immediate     = rsp_rec_ff.immediate;
   assign rsp_bus.length        = rsp_rec_ff.length;
   assign rsp_bus.status        = rsp_rec_ff.status;

endmodule

@@ rtl/core/x86d_collect.sv @@
// ----------------------------------------------------------------------------
// x86d_collect
// Byte collector: holds opcode, mod-reg-rm, displacement and immediate bytes
// and flags the byte that completes an instruction, is unknown or truncates.
// ----------------------------------------------------------------------------
module x86d_collect (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         code_byte,
   input  logic               stream_end,
   output logic               emit,
   output x86d_pkg::snap_type snap
);
   import x86d_pkg::*;

   logic [7:0]  opcode_ff, opcode_in;
   logic [7:0]  modrm_ff, modrm_in;
   logic [2:0]  taken_ff, taken_in;
   logic [2:0]  needed_ff, needed_in;
   logic [15:0] disp_ff, disp_in;
   logic [15:0] imm_ff, imm_in;

   op_class_type cls;
   logic [2:0]   taken_nx;
   logic [2:0]   needed_nx;
   logic [2:0]   k;
   logic [2:0]   dl;
   logic [2:0]   mm;
   logic         bad_op;
   logic         done;

   // Gather this byte into the held fields
   always_comb begin
      opcode_in = opcode_ff;
      modrm_in  = modrm_ff;
      disp_in   = disp_ff;
      imm_in    = imm_ff;
      taken_nx  = taken_ff;
      needed_nx = needed_ff;
      bad_op    = 1'b0;
      k         = 3'd0;
      mm        = 3'd0;
      dl        = 3'd0;
      cls       = op_class(opcode_ff);
      if (taken_ff == 3'd0) begin
         cls       = op_class(code_byte);
         opcode_in = code_byte;
         modrm_in  = 8'h00;
         disp_in   = 16'h0000;
         imm_in    = 16'h0000;
         if (cls == CL_NONE) begin
            bad_op = 1'b1;
         end else begin
            taken_nx  = 3'd1;
            needed_nx = has_modrm(cls) ? 3'd0 : 3'd1 + {1'b0, imm_len(code_byte, cls)};
         end
      end else begin
         if (has_modrm(cls) && taken_ff == 3'd1) begin
            modrm_in  = code_byte;
            needed_nx = 3'd2 + {1'b0, disp_len(code_byte)} + {1'b0, imm_len(opcode_ff, cls)};
         end else begin
            mm = has_modrm(cls) ? 3'd1 : 3'd0;
            dl = has_modrm(cls) ? {1'b0, disp_len(modrm_ff)} : 3'd0;
            if (taken_ff >= 3'd1 + mm) begin
               k = taken_ff - 3'd1 - mm;
               if (k < dl) begin
                  if (k == 3'd0) disp_in[7:0]  = code_byte;
                  else           disp_in[15:8] = code_byte;
               end else if (k - dl < 3'd2) begin
                  if (k == dl)   imm_in[7:0]   = code_byte;
                  else           imm_in[15:8]  = code_byte;
               end
            end
         end
         taken_nx = taken_ff + 3'd1;
      end
   end

   // Completion, truncation and the state that follows
   always_comb begin
      done     = (needed_nx != 3'd0) && (taken_nx >= needed_nx);
      emit     = bad_op || done || stream_end;
      taken_in = taken_nx;
      needed_in = needed_nx;
      if (done || stream_end) begin
         taken_in  = 3'd0;
         needed_in = 3'd0;
      end
      snap.opcode = opcode_in;
      snap.modrm  = modrm_in;
      snap.disp   = disp_in;
      snap.imm    = imm_in;
      snap.length = taken_nx;
      if (bad_op) begin
         snap.kind   = SNAP_BAD_OPCODE;
         snap.length = 3'd1;
      end else if (done) begin
         snap.kind = SNAP_DECODE;
      end else begin
         snap.kind = SNAP_TRUNC;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         opcode_ff <= 8'h00;
         modrm_ff  <= 8'h00;
         taken_ff  <= 3'd0;
         needed_ff <= 3'd0;
         disp_ff   <= 16'h0000;
         imm_ff    <= 16'h0000;
      end else if (step) begin
         opcode_ff <= opcode_in;
         modrm_ff  <= modrm_in;
         taken_ff  <= taken_in;
         needed_ff <= needed_in;
         disp_ff   <= disp_in;
         imm_ff    <= imm_in;
      end
   end

endmodule

@@ rtl/core/x86d_decode.sv @@
// ----------------------------------------------------------------------------
// x86d_decode
// Turns a snapshot of a completed instruction or an error into one decoded record.
// ----------------------------------------------------------------------------
module x86d_decode (
   input  x86d_pkg::snap_type   snap,
   output x86d_pkg::record_type rec
);
   import x86d_pkg::*;

   op_class_type cls;
   logic [7:0]   op;
   logic [7:0]   m;
   logic         w;
   logic [1:0]   rk;
   logic [3:0]   rr;
   logic [3:0]   af;
   logic [15:0]  disp;
   logic [3:0]   reg_fld;
   logic         bad_ext;

   always_comb begin
      op      = snap.opcode;
      m       = snap.modrm;
      cls     = op_class(op);
      w       = op[0];
      reg_fld = {w, m[5:3]};
      bad_ext = 1'b0;

      // r/m operand
      rk   = OPND_REG;
      rr   = 4'd0;
      af   = 4'd0;
      disp = 16'h0000;
      if (has_modrm(cls)) begin
         if (m[7:6] == MOD_REG) begin
            rr = {w, m[2:0]};
         end else begin
            rk   = OPND_MEM;
            af   = (m[7:6] == 2'd0 && m[2:0] == RM_DIRECT) ? AF_DIRECT : {1'b0, m[2:0]};
            disp = sext(snap.disp, disp_len(m));
         end
      end

      rec               = '0;
      rec.wide_op       = w;
      rec.operand_total = 2'd2;
      rec.address_form  = af;
      rec.displacement  = disp;
      rec.immediate     = sext(snap.imm, imm_len(op, cls));
      rec.length        = snap.length;
      rec.status        = ST_OK;

      // Per-class operands
      unique case (cls)
         CL_REGMEM: begin
            rec.mnemonic = (op >= OP_MOV_RM_LO) ? MN_MOV :
                           (op >= OP_CMP_BASE)  ? MN_CMP :
                           (op >= OP_SUB_BASE)  ? MN_SUB : MN_ADD;
            if (op[1]) begin
               rec.dest_kind = OPND_REG;
               rec.dest_reg  = reg_fld;
               rec.src_kind  = rk;
               rec.src_reg   = rr;
            end else begin
               rec.dest_kind = rk;
               rec.dest_reg  = rr;
               rec.src_kind  = OPND_REG;
               rec.src_reg   = reg_fld;
            end
         end
         CL_MOVIMM: begin
            rec.mnemonic  = MN_MOV;
            rec.wide_op   = op[3];
            rec.dest_kind = OPND_REG;
            rec.dest_reg  = {op[3], op[2:0]};
            rec.src_kind  = OPND_IMM;
         end
         CL_ACCIMM: begin
            rec.mnemonic  = (op >= OP_CMP_ACC) ? MN_CMP :
                            (op >= OP_SUB_ACC) ? MN_SUB : MN_ADD;
            rec.dest_kind = OPND_REG;
            rec.dest_reg  = {w, 3'd0};
            rec.src_kind  = OPND_IMM;
         end
         CL_GROUP: begin
            rec.dest_kind = rk;
            rec.dest_reg  = rr;
            rec.src_kind  = OPND_IMM;
            if (m[5:3] == EXT_ADD)      rec.mnemonic = MN_ADD;
            else if (m[5:3] == EXT_SUB) rec.mnemonic = MN_SUB;
            else if (m[5:3] == EXT_CMP) rec.mnemonic = MN_CMP;
            else                        bad_ext = 1'b1;
         end
         default: begin
            // short jumps and loops
            rec.wide_op       = 1'b0;
            rec.operand_total = 2'd1;
            rec.dest_kind     = OPND_IMM;
            if (op <= OP_JCC_HI)     rec.mnemonic = MN_JCC_BASE + {1'b0, op[3:0]};
            else if (op == OP_LOOP)  rec.mnemonic = MN_LOOP;
            else if (op == OP_LOOPZ) rec.mnemonic = MN_LOOPZ;
            else if (op == OP_LOOPNZ) rec.mnemonic = MN_LOOPNZ;
            else                     rec.mnemonic = MN_JCXZ;
         end
      endcase

      // Error records carry only length and status
      if (snap.kind != SNAP_DECODE || bad_ext) begin
         rec        = '0;
         rec.length = snap.length;
         rec.status = (snap.kind == SNAP_BAD_OPCODE) ? ST_BAD_OPCODE :
                      (snap.kind == SNAP_TRUNC)      ? ST_TRUNC : ST_BAD_EXT;
      end
   end

endmodule
